### hdl/lesp_pkg.sv
// Shared constants for the shortest-path engine.
// No dependencies.
package lesp_pkg;
  localparam int ROOMS = 1024;
  localparam int EXITS = 4096;
  localparam logic [21:0] COST_INF = 22'd2148575;
  localparam logic [15:0] TOLL_RESET = 16'd10000;
  localparam logic [10:0] ROOM_COUNT_RESET = 11'd1024;
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;
  localparam logic [1:0] LOCK_OPEN = 2'd0;
  localparam logic [1:0] LOCK_PASS = 2'd1;
  localparam logic [1:0] LOCK_BLOCK = 2'd2;
  localparam logic CFG_TOLL = 1'b0;
  localparam logic CFG_ROOM_COUNT = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
endpackage

### hdl/lesp_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lesp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hdl/locked_exit_shortest_paths_top.sv
// Top level of the shortest-path engine: sequencer plus its memories.
// Depends on lesp_pkg and lesp_ram.
//
// Command interface: an item is taken when start is high and busy is low.
// Compute and query items each produce one result beat, shown for one cycle
// with done high; the receiver cannot stall it. Load keeps busy high through
// LOAD and LOAD2 (LOAD only when the item is dropped); query keeps it high
// through QRY and QRY2 and registers its beat in QRY2. Clear walks every room
// entry. Compute first sweeps every room label, seeds the start room when it
// lies below the room count, then processes the work ring: each popped room
// goes through POP, POP2 and EXIT2, each exit on its list through EXIT and
// DEST, plus DEST2 when the exit may be taken, and the final check of the
// empty ring is made in POP; every step goes through single-port memories
// with registered read. The search is label-correcting, so a room may be
// popped more than once. After reset the room table is swept once with busy high. Configuration
// writes are taken only while idle with no command offered (cfg_ready).
module locked_exit_shortest_paths_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [9:0]  room_index,
  input  logic        dest_valid,
  input  logic [9:0]  dest_room,
  input  logic [1:0]  lock_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        kind,
  output logic        reachable,
  output logic [21:0] path_cost,
  output logic        prev_valid,
  output logic [9:0]  prev_room,
  output logic [11:0] prev_exit
);
  import lesp_pkg::*;
  localparam int RW = $clog2(ROOMS);
  localparam int EW = $clog2(EXITS);
  localparam int RC = RW + 1; // room count width
  localparam int EC = EW + 1; // exit count / null mark

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_CLR   = 14'b00000000000100,
    S_LOAD  = 14'b00000000001000,
    S_LOAD2 = 14'b00000000010000,
    S_QRY   = 14'b00000000100000,
    S_QRY2  = 14'b00000001000000,
    S_SWEEP = 14'b00000010000000,
    S_POP   = 14'b00000100000000,
    S_POP2  = 14'b00001000000000,
    S_EXIT  = 14'b00010000000000,
    S_EXIT2 = 14'b00100000000000,
    S_DEST  = 14'b01000000000000,
    S_DEST2 = 14'b10000000000000
  } state_t;

  state_t state;
  logic [15:0] toll;
  logic [10:0] room_count;
  logic [RC-1:0] cnt;          // sweep counter
  logic [EC-1:0] exit_total;
  logic [1:0] cmd_func;
  logic [RW-1:0] cmd_room;
  logic [10:0] cmd_dest;       // bit 10 valid
  logic [1:0] cmd_lock;
  logic [RC-1:0] count_eff;
  logic [RW-1:0] cur_room;
  logic [21:0] base;
  logic [EC-1:0] cur_exit;
  logic [RW-1:0] d_room;
  logic [21:0] new_cost;
  logic [RW-1:0] ring_head, ring_tail;
  logic [RC-1:0] ring_fill;

  // room label memory: {queued, cost, prev_room(RW+1), prev_exit(EC)}
  localparam int LW = 1 + 22 + RC + EC;
  logic lab_we; logic [RW-1:0] lab_addr; logic [LW-1:0] lab_wd, lab_rd;
  lesp_ram #(.WIDTH(LW), .DEPTH(ROOMS)) u_lab (
    .clk(clk), .we(lab_we), .addr(lab_addr), .wdata(lab_wd), .rdata(lab_rd));
  // first exit per room
  logic fe_we; logic [RW-1:0] fe_addr; logic [EC-1:0] fe_wd, fe_rd;
  lesp_ram #(.WIDTH(EC), .DEPTH(ROOMS)) u_fe (
    .clk(clk), .we(fe_we), .addr(fe_addr), .wdata(fe_wd), .rdata(fe_rd));
  // exit store: {dest_valid, dest, lock, link}
  localparam int XW = 1 + 10 + 2 + EC;
  logic ex_we; logic [EW-1:0] ex_addr; logic [XW-1:0] ex_wd, ex_rd;
  lesp_ram #(.WIDTH(XW), .DEPTH(EXITS)) u_ex (
    .clk(clk), .we(ex_we), .addr(ex_addr), .wdata(ex_wd), .rdata(ex_rd));
  // work ring
  logic rg_we; logic [RW-1:0] rg_addr; logic [RW-1:0] rg_wd, rg_rd;
  lesp_ram #(.WIDTH(RW), .DEPTH(ROOMS)) u_rg (
    .clk(clk), .we(rg_we), .addr(rg_addr), .wdata(rg_wd), .rdata(rg_rd));

  logic lab_q; logic [21:0] lab_cost; logic [RC-1:0] lab_prev; logic [EC-1:0] lab_pe;
  assign {lab_q, lab_cost, lab_prev, lab_pe} = lab_rd;
  logic x_dv; logic [9:0] x_dr; logic [1:0] x_lk; logic [EC-1:0] x_link;
  assign {x_dv, x_dr, x_lk, x_link} = ex_rd;

  localparam logic [RC-1:0] ROOM_NONE = RC'(ROOMS);
  localparam logic [EC-1:0] EXIT_NULL = EC'(EXITS);
  localparam logic [LW-1:0] LAB_RESET = {1'b0, COST_INF, ROOM_NONE, EXIT_NULL};

  assign busy = (state != S_IDLE);
  // Hold register writes off while a command runs or is being offered.
  assign cfg_ready = (state == S_IDLE) && !start;

  logic accept;
  assign accept = start && !busy;
  logic [RW:0] room_ext;
  assign room_ext = {1'b0, cmd_room};
  logic room_ok; // room within ROOMS
  assign room_ok = ({22'd0, cmd_room} < 32'(ROOMS));
  logic edge_ok;
  assign edge_ok = x_dv && ({22'd0, x_dr} < 32'(count_eff)) && (x_lk <= LOCK_PASS);
  logic [21:0] edge_cost;
  assign edge_cost = base + 22'd1 + ((x_lk == LOCK_PASS) ? {6'd0, toll} : 22'd0);

  // memory port control
  always_comb begin
    lab_we = 1'b0; lab_addr = cmd_room; lab_wd = LAB_RESET;
    fe_we = 1'b0; fe_addr = cmd_room; fe_wd = EXIT_NULL;
    ex_we = 1'b0; ex_addr = cur_exit[EW-1:0]; ex_wd = '0;
    rg_we = 1'b0; rg_addr = ring_head; rg_wd = cur_room;
    unique case (state)
      S_INIT: begin
        lab_we = 1'b1; lab_addr = cnt[RW-1:0];
        fe_we = 1'b1; fe_addr = cnt[RW-1:0];
      end
      S_CLR: begin
        fe_we = 1'b1; fe_addr = cnt[RW-1:0];
      end
      S_SWEEP: begin
        lab_we = 1'b1; lab_addr = cnt[RW-1:0];
      end
      S_LOAD2: begin
        ex_we = 1'b1; ex_addr = exit_total[EW-1:0];
        ex_wd = {cmd_dest, cmd_lock, fe_rd};
        fe_we = 1'b1; fe_wd = exit_total;
      end
      S_POP: begin
        rg_addr = ring_head;
      end
      S_POP2: begin
        lab_addr = rg_rd; fe_addr = rg_rd;
      end
      S_EXIT2: begin
        // popped room: drop its queued mark, keep the rest of the label
        lab_we = 1'b1; lab_addr = cur_room;
        lab_wd = {1'b0, lab_cost, lab_prev, lab_pe};
      end
      S_EXIT: begin
        ex_addr = cur_exit[EW-1:0];
      end
      S_DEST: begin
        // seeding reads the start room, otherwise the exit's destination
        lab_addr = (cur_exit == EXIT_NULL) ? d_room : x_dr[RW-1:0];
      end
      S_DEST2: begin
        lab_addr = d_room;
        if (new_cost < lab_cost) begin
          lab_we = 1'b1;
          if (cur_exit == EXIT_NULL) begin
            lab_wd = {1'b1, new_cost, ROOM_NONE, EXIT_NULL};
          end else begin
            lab_wd = {1'b1, new_cost, {1'b0, cur_room}, cur_exit};
          end
          if (!lab_q && ring_fill < RC'(ROOMS)) begin
            rg_we = 1'b1; rg_addr = ring_tail; rg_wd = d_room;
          end
        end
      end
      S_QRY: begin
        lab_addr = cmd_room;
      end
      default: begin
      end
    endcase
  end

  logic [EC-1:0] lab_pe_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; cnt <= '0; exit_total <= '0;
      toll <= TOLL_RESET; room_count <= ROOM_COUNT_RESET;
      ring_head <= '0; ring_tail <= '0; ring_fill <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOLL) toll <= cfg_data;
        else room_count <= cfg_data[10:0];
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == RC'(ROOMS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cmd_func <= func; cmd_room <= room_index[RW-1:0];
            cmd_dest <= {dest_valid, dest_room};
            cmd_lock <= (lock_kind == 2'd3) ? LOCK_BLOCK : lock_kind;
            count_eff <= ({21'd0, room_count} > 32'(ROOMS)) ? RC'(ROOMS)
                                                           : RC'(room_count);
            cnt <= '0;
            unique case (func)
              FUNC_CLEAR: state <= S_CLR;
              FUNC_LOAD: state <= S_LOAD;
              FUNC_COMPUTE: state <= S_SWEEP;
              default: state <= S_QRY;
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == RC'(ROOMS - 1)) begin
            exit_total <= '0; state <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (exit_total >= EC'(EXITS) || !room_ok) state <= S_IDLE;
          else state <= S_LOAD2;
        end
        S_LOAD2: begin
          exit_total <= exit_total + 1'b1; state <= S_IDLE;
        end
        S_QRY: state <= S_QRY2;
        S_QRY2: begin
          done <= 1'b1; kind <= KIND_QUERY;
          if (!room_ok) begin
            reachable <= 1'b0; path_cost <= COST_INF;
            prev_valid <= 1'b0; prev_room <= '0; prev_exit <= '0;
          end else begin
            reachable <= (lab_cost < COST_INF); path_cost <= lab_cost;
            prev_valid <= (lab_prev < ROOM_NONE);
            prev_room <= (lab_prev < ROOM_NONE) ? 10'(lab_prev) : 10'd0;
            prev_exit <= (lab_prev < ROOM_NONE) ? 12'(lab_pe) : 12'd0;
          end
          state <= S_IDLE;
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == RC'(ROOMS - 1)) begin
            ring_head <= '0; ring_tail <= '0; ring_fill <= '0;
            if ({1'b0, room_ext} < {1'b0, count_eff}) begin
              // seed: start room at cost 0 in ring, processed by DEST2 path
              d_room <= cmd_room; new_cost <= '0; cur_room <= cmd_room;
              cur_exit <= EXIT_NULL; state <= S_DEST;
            end else begin
              state <= S_IDLE; done <= 1'b1; kind <= KIND_DONE;
              reachable <= 1'b0; path_cost <= '0; prev_valid <= 1'b0;
              prev_room <= '0; prev_exit <= '0;
            end
          end
        end
        S_POP: begin
          if (ring_fill == '0) begin
            state <= S_IDLE; done <= 1'b1; kind <= KIND_DONE;
            reachable <= 1'b0; path_cost <= '0; prev_valid <= 1'b0;
            prev_room <= '0; prev_exit <= '0;
          end else state <= S_POP2;
        end
        S_POP2: begin
          cur_room <= rg_rd;
          ring_head <= (ring_head == RW'(ROOMS - 1)) ? '0 : ring_head + 1'b1;
          ring_fill <= ring_fill - 1'b1;
          state <= S_EXIT2;
        end
        S_EXIT2: begin
          // label and first exit now read; queued mark dropped by the comb write
          base <= lab_cost; cur_exit <= fe_rd;
          state <= S_EXIT;
        end
        S_EXIT: begin
          if (cur_exit >= EXIT_NULL) state <= S_POP;
          else state <= S_DEST;
        end
        S_DEST: begin
          if (cur_exit == EXIT_NULL) begin
            state <= S_DEST2; // seeding the start room, label read this cycle
          end else if (edge_ok) begin
            d_room <= x_dr[RW-1:0]; new_cost <= edge_cost;
            state <= S_DEST2;
            cur_exit <= cur_exit;
            lab_pe_hold <= x_link;
          end else begin
            cur_exit <= x_link; state <= S_EXIT;
          end
        end
        S_DEST2: begin
          if (new_cost < lab_cost && !lab_q && ring_fill < RC'(ROOMS)) begin
            ring_tail <= (ring_tail == RW'(ROOMS - 1)) ? '0 : ring_tail + 1'b1;
            ring_fill <= ring_fill + 1'b1;
          end
          if (cur_exit == EXIT_NULL) state <= S_POP;
          else begin
            cur_exit <= lab_pe_hold; state <= S_EXIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/lesp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the shortest-path engine: tracks register writes and items,
// predicts each result beat and compares it with the block's output.
// Depends on lesp_pkg.
module lesp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func,
  input  logic [9:0]  room_index,
  input  logic        dest_valid,
  input  logic [9:0]  dest_room,
  input  logic [1:0]  lock_kind,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        done,
  input  logic        kind,
  input  logic        reachable,
  input  logic [21:0] path_cost,
  input  logic        prev_valid,
  input  logic [9:0]  prev_room,
  input  logic [11:0] prev_exit,
  output int          fails,
  output int          pending
);
  import lesp_pkg::*;

  typedef struct {
    logic        kind;
    logic        reachable;
    logic [21:0] path_cost;
    logic        prev_valid;
    logic [9:0]  prev_room;
    logic [11:0] prev_exit;
  } answer_t;

  answer_t answers[$];

  logic [15:0] toll_q;
  logic [10:0] room_count_q;

  logic        exit_has_dest[EXITS];
  logic [9:0]  exit_to[EXITS];
  logic [1:0]  exit_kind[EXITS];
  int          exit_next[EXITS];
  int          first_exit[ROOMS];
  int          exits_loaded;
  int          label_cost[ROOMS];
  int          label_room[ROOMS];
  int          label_exit[ROOMS];
  bit          in_ring[ROOMS];

  function automatic int live_rooms();
    return (room_count_q > ROOMS) ? ROOMS : int'(room_count_q);
  endfunction

  task automatic run_search(input int origin);
    int limit;
    int here;
    int e;
    int step_cost;
    int ring[$];
    limit = live_rooms();
    for (int r = 0; r < ROOMS; r++) begin
      label_cost[r] = COST_INF;
      label_room[r] = ROOMS;
      label_exit[r] = EXITS;
      in_ring[r] = 0;
    end
    if (origin >= limit) return;
    label_cost[origin] = 0;
    ring.push_back(origin);
    in_ring[origin] = 1;
    while (ring.size() > 0) begin
      here = ring.pop_front();
      in_ring[here] = 0;
      e = first_exit[here];
      while (e < EXITS) begin
        if (exit_has_dest[e] && exit_to[e] < limit && exit_kind[e] <= LOCK_PASS) begin
          step_cost = label_cost[here] + 1 + ((exit_kind[e] == LOCK_PASS) ? toll_q : 0);
          if (step_cost < label_cost[exit_to[e]]) begin
            label_cost[exit_to[e]] = step_cost;
            label_room[exit_to[e]] = here;
            label_exit[exit_to[e]] = e;
            if (!in_ring[exit_to[e]]) begin
              ring.push_back(exit_to[e]);
              in_ring[exit_to[e]] = 1;
            end
          end
        end
        e = exit_next[e];
      end
    end
  endtask

  function automatic int field_ok(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    int ok;
    if (rst) begin
      toll_q <= TOLL_RESET;
      room_count_q <= ROOM_COUNT_RESET;
      for (int r = 0; r < ROOMS; r++) first_exit[r] = EXITS;
      exits_loaded = 0;
      run_search(ROOMS);
      answers.delete();
      fails <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOLL) toll_q <= cfg_data;
        else room_count_q <= cfg_data[10:0];
      end
      // Compare the beat on the outputs with the oldest answer.
      if (done) begin
        if (answers.size() == 0) begin
          $error("result beat with no answer waiting");
          fails <= fails + 1;
        end else begin
          a = answers.pop_front();
          ok = field_ok("kind", a.kind, kind);
          ok &= field_ok("reachable", a.reachable, reachable);
          ok &= field_ok("path_cost", a.path_cost, path_cost);
          ok &= field_ok("prev_valid", a.prev_valid, prev_valid);
          ok &= field_ok("prev_room", a.prev_room, prev_room);
          ok &= field_ok("prev_exit", a.prev_exit, prev_exit);
          if (!ok) fails <= fails + 1;
        end
      end
      if (start && !busy) begin
        a = '{default: '0};
        case (func)
          FUNC_CLEAR: begin
            for (int r = 0; r < ROOMS; r++) first_exit[r] = EXITS;
            exits_loaded = 0;
          end
          FUNC_LOAD: begin
            if (exits_loaded < EXITS) begin
              exit_has_dest[exits_loaded] = dest_valid;
              exit_to[exits_loaded] = dest_room;
              exit_kind[exits_loaded] = (lock_kind == 2'd3) ? LOCK_BLOCK : lock_kind;
              exit_next[exits_loaded] = first_exit[room_index];
              first_exit[room_index] = exits_loaded;
              exits_loaded++;
            end
          end
          FUNC_COMPUTE: begin
            run_search(room_index);
            a.kind = KIND_DONE;
            answers.push_back(a);
          end
          default: begin
            a.kind = KIND_QUERY;
            a.reachable = label_cost[room_index] < COST_INF;
            a.path_cost = 22'(label_cost[room_index]);
            if (label_room[room_index] < ROOMS) begin
              a.prev_valid = 1'b1;
              a.prev_room = 10'(label_room[room_index]);
              a.prev_exit = 12'(label_exit[room_index]);
            end
            answers.push_back(a);
          end
        endcase
      end
    end
    pending <= answers.size();
  end

endmodule

### tb/locked_exit_shortest_paths_top_test.sv
`timescale 1ns / 1ps
// Top of the shortest-path engine testbench: clock, reset, command and
// register stimulus, verdict. Depends on lesp_pkg, lesp_checker and the block.
module locked_exit_shortest_paths_top_test;
  import lesp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_CLEAR;
  logic [9:0]  room_index = '0;
  logic        dest_valid = 1'b0;
  logic [9:0]  dest_room = '0;
  logic [1:0]  lock_kind = LOCK_OPEN;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TOLL;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        kind;
  logic        reachable;
  logic [21:0] path_cost;
  logic        prev_valid;
  logic [9:0]  prev_room;
  logic [11:0] prev_exit;
  int          fails;
  int          pending;

  int items_sent = 0;
  int settings_used = 0;
  int searches = 0;
  bit calm = 0;       // phase with no gaps between items
  int rooms_now = 1024;

  always #5 clk = ~clk;

  locked_exit_shortest_paths_top dut (.*);

  lesp_checker chk (.*);

  // Safety net: far beyond the slowest legal run.
  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one command beat and hold it until the block takes it.
  // Start stays high on return so back-to-back beats need no toggle.
  task automatic issue(input logic [1:0] f, input logic [9:0] r, input logic dv,
                       input logic [9:0] dr, input logic [1:0] lk);
    int g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    room_index <= r;
    dest_valid <= dv;
    dest_room <= dr;
    lock_kind <= lk;
    do @(posedge clk); while (busy);
    items_sent++;
    if (f == FUNC_COMPUTE) searches++;
  endtask

  // Drain: every answer back, then let a clear or load finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROOM_COUNT) begin
      rooms_now = (value[10:0] > 1024) ? 1024 : int'(value[10:0]);
      settings_used++;
    end
  endtask

  // Room inside the current count most of the time, anywhere otherwise.
  function automatic logic [9:0] pick_room();
    if (rooms_now > 0 && $urandom_range(0, 9) != 0)
      return 10'($urandom_range(0, rooms_now - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic load_random(input int n);
    for (int i = 0; i < n; i++)
      issue(FUNC_LOAD, pick_room(), $urandom_range(0, 9) != 0, pick_room(),
            2'($urandom_range(0, 3)));
  endtask

  initial begin
    int n;
    int sel;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: queries at reset, extreme rooms, every lock kind.
    issue(FUNC_QUERY, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_COMPUTE, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_LOAD, 10'd0, 1'b1, 10'd1023, LOCK_PASS);
    issue(FUNC_LOAD, 10'd1023, 1'b1, 10'd0, LOCK_OPEN);
    issue(FUNC_LOAD, 10'd0, 1'b1, 10'd5, 2'd3);
    issue(FUNC_LOAD, 10'd0, 1'b1, 10'd6, LOCK_BLOCK);
    issue(FUNC_LOAD, 10'd0, 1'b0, 10'd7, LOCK_OPEN);
    issue(FUNC_LOAD, 10'd1023, 1'b1, 10'd7, LOCK_OPEN);
    issue(FUNC_COMPUTE, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd1023, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd7, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd5, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    settle();
    // Extremes of both registers; destinations past the count get skipped.
    write_reg(CFG_TOLL, 16'hFFFF);
    write_reg(CFG_ROOM_COUNT, 16'hFFFF);
    issue(FUNC_COMPUTE, 10'd1023, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    settle();
    write_reg(CFG_TOLL, 16'd0);
    write_reg(CFG_ROOM_COUNT, 16'd0);
    issue(FUNC_COMPUTE, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    settle();
    write_reg(CFG_ROOM_COUNT, 16'd8);
    issue(FUNC_COMPUTE, 10'd1023, 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_QUERY, 10'd1023, 1'b0, 10'd0, LOCK_OPEN);

    // Small dense graph over eight rooms, loaded back to back, then searched.
    issue(FUNC_CLEAR, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    calm = 1;
    load_random(40);
    calm = 0;
    issue(FUNC_COMPUTE, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    for (int r = 0; r < 8; r++) issue(FUNC_QUERY, 10'(r), 1'b0, 10'd0, LOCK_OPEN);
    issue(FUNC_CLEAR, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
    settle();

    // Random phases: set registers, build a graph, search, then query it.
    while (items_sent < 1000) begin
      calm = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) write_reg(CFG_ROOM_COUNT, 16'd1);
      else if (sel == 1) write_reg(CFG_ROOM_COUNT, 16'd1024);
      else if (sel == 2) write_reg(CFG_ROOM_COUNT, {5'($urandom_range(0, 31)), 11'd0});
      else write_reg(CFG_ROOM_COUNT, {5'($urandom_range(0, 31)), 11'd0}
                                     | 16'($urandom_range(2, 48)));
      sel = $urandom_range(0, 3);
      write_reg(CFG_TOLL, sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF
                                           : 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 2) != 0) issue(FUNC_CLEAR, 10'd0, 1'b0, 10'd0, LOCK_OPEN);
      load_random($urandom_range(5, 60));
      for (int k = 0; k < 3; k++) begin
        issue(FUNC_COMPUTE, pick_room(), 1'($urandom), 10'($urandom), 2'($urandom));
        n = $urandom_range(4, 20);
        for (int q = 0; q < n; q++) begin
          // Sprinkle noise: stray loads between queries.
          if ($urandom_range(0, 7) == 0) load_random(1);
          else issue(FUNC_QUERY, pick_room(), 1'($urandom), 10'($urandom), 2'($urandom));
        end
      end
      settle();
    end

    settle();
    repeat (200) @(posedge clk);
    $display("Ran %0d items including %0d searches over %0d room-count settings.",
             items_sent, searches, settings_used);
    $display("Outstanding answers at end: %0d, failures: %0d.", pending, fails);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lesp_pkg.sv
hdl/lesp_ram.sv
hdl/locked_exit_shortest_paths_top.sv
tb/lesp_checker.sv
tb/locked_exit_shortest_paths_top_test.sv
